[src/symmetry_coordinate_transform_unit_macros.svh]
// assertion macros shared by the symmetry transform rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SYMMETRY_COORDINATE_TRANSFORM_UNIT_MACROS_SVH
`define SYMMETRY_COORDINATE_TRANSFORM_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle (consequent may carry a delay)
`define SCT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("sct assertion failed");

// antecedent holds, consequent holds in the next cycle
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sct assertion failed");

`endif

[src/sct_pkg.sv]
// shared constants, types and saturation helpers of the symmetry transform
// no dependencies
`default_nettype none
package sct_pkg;
   localparam int WORD_W     = 48;
   localparam int HALF_W     = 24;
   localparam int COORD_W    = 32;
   localparam int SHIFT_W    = 4;
   localparam int ADDR_W     = 10;
   localparam int OPIDX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int OP_BASE    = 32;
   localparam int OP_WORDS   = 12;
   localparam int CONV_WORDS = 21;
   localparam int FWD_BASE   = 0;
   localparam int INV_BASE   = 9;
   localparam int ORG_BASE   = 18;
   localparam int TRN_OFS    = 9;
   localparam int ACC_W      = 100;
   localparam int LATENCY    = 10;

   localparam int DEF_MAX_OPERATORS = 64;
   localparam int DEF_COEF_FRAC     = 32;
   localparam int DEF_COORD_FRAC    = 16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_XFORM = 1'b1;

   typedef struct packed {
      logic valid;
      logic bad;
   } sct_ctrl_type;

   typedef struct packed {
      logic                   bad;
      logic [2:0][COORD_W-1:0] coord;
   } sct_side_type;

   localparam logic signed [ACC_W-1:0] WORD_MAX =
      {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] COORD_MAX =
      {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};

   function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic [WORD_W-1:0] r;
      if (v > WORD_MAX) r = {1'b0, {(WORD_W-1){1'b1}}};
      else if (v < ~WORD_MAX) r = {1'b1, {(WORD_W-1){1'b0}}};
      else r = v[WORD_W-1:0];
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > COORD_MAX) r = {1'b0, {(COORD_W-1){1'b1}}};
      else if (v < ~COORD_MAX) r = {1'b1, {(COORD_W-1){1'b0}}};
      else r = v[COORD_W-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

[src/sct_datapath.sv]
// ten-stage fixed point datapath: to fractional, operator, back to cartesian
// depends on sct_pkg and the macro header
`default_nettype none
`include "symmetry_coordinate_transform_unit_macros.svh"
module sct_datapath
   import sct_pkg::*;
#(
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sct_ctrl_type              in_ctrl,
   input  wire logic [COORD_W-1:0]        in_coord [3],
   input  wire logic [SHIFT_W-1:0]        in_shift [3],
   input  wire logic [WORD_W-1:0]         in_fwd   [9],
   input  wire logic [WORD_W-1:0]         in_inv   [9],
   input  wire logic [WORD_W-1:0]         in_org   [3],
   input  wire logic [WORD_W-1:0]         in_rot   [9],
   input  wire logic [WORD_W-1:0]         in_trn   [3],
   output sct_ctrl_type                   out_ctrl,
   output logic [COORD_W-1:0]             out_result [3]
);
   localparam int RND3 = 2 * COEF_FRAC_BITS - COORD_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF1 = {{(ACC_W-1){1'b0}}, 1'b1} << (COORD_FRAC_BITS-1);
   localparam logic signed [ACC_W-1:0] HALF2 = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);
   localparam logic signed [ACC_W-1:0] HALF3 = {{(ACC_W-1){1'b0}}, 1'b1} << (RND3-1);
   localparam int PA_W = HALF_W + 1 + COORD_W;
   localparam int PP_W = 2 * (HALF_W + 1);
   localparam int D_W  = WORD_W + 1;

   logic         valid_ff [LATENCY];
   sct_side_type side_ff  [LATENCY];
   logic [WORD_W-1:0]  rot_ff   [3][9];
   logic [WORD_W-1:0]  trn_ff   [4][3];
   logic [SHIFT_W-1:0] shift_ff [4][3];
   logic [WORD_W-1:0]  org_ff   [6][3];
   logic [WORD_W-1:0]  inv_ff   [7][9];

   logic signed [PA_W-1:0]  pa_hi_ff [3][3];
   logic signed [PA_W-1:0]  pa_lo_ff [3][3];
   logic signed [ACC_W-1:0] acc1_ff  [3];
   logic [WORD_W-1:0]       f_ff     [3];
   logic signed [PP_W-1:0]  pd_ff    [3][3][4];
   logic signed [ACC_W-1:0] acc2_ff  [3];
   logic [WORD_W-1:0]       g_ff     [3];
   logic signed [D_W-1:0]   d_ff     [3];
   logic signed [PP_W-1:0]  ph_ff    [3][3][4];
   logic signed [ACC_W-1:0] acc3_ff  [3];
   logic [COORD_W-1:0]      res_ff   [3];

   logic signed [ACC_W-1:0] acc1_in [3];
   logic signed [ACC_W-1:0] acc2_in [3];
   logic signed [ACC_W-1:0] acc3_in [3];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LATENCY; s++) valid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= in_ctrl.valid;
         for (int s = 1; s < LATENCY; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // sideband and coefficient carry
   always_ff @(posedge clock) begin
      side_ff[0].bad <= in_ctrl.bad;
      for (int i = 0; i < 3; i++) side_ff[0].coord[i] <= in_coord[i];
      for (int s = 1; s < LATENCY; s++) side_ff[s] <= side_ff[s-1];
      for (int k = 0; k < 9; k++) begin
         rot_ff[0][k] <= in_rot[k];
         inv_ff[0][k] <= in_inv[k];
         for (int s = 1; s < 3; s++) rot_ff[s][k] <= rot_ff[s-1][k];
         for (int s = 1; s < 7; s++) inv_ff[s][k] <= inv_ff[s-1][k];
      end
      for (int k = 0; k < 3; k++) begin
         trn_ff[0][k]   <= in_trn[k];
         shift_ff[0][k] <= in_shift[k];
         org_ff[0][k]   <= in_org[k];
         for (int s = 1; s < 4; s++) begin
            trn_ff[s][k]   <= trn_ff[s-1][k];
            shift_ff[s][k] <= shift_ff[s-1][k];
         end
         for (int s = 1; s < 6; s++) org_ff[s][k] <= org_ff[s-1][k];
      end
   end

   // stage one products, forward matrix split into high and low halves
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pa_hi_ff[i][j] <= $signed(in_fwd[i*3+j][WORD_W-1:HALF_W]) *
                              $signed(in_coord[j]);
            pa_lo_ff[i][j] <= $signed({1'b0, in_fwd[i*3+j][HALF_W-1:0]}) *
                              $signed(in_coord[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc1_in[i] = ACC_W'($signed(org_ff[0][i])) <<< COORD_FRAC_BITS;
         for (int j = 0; j < 3; j++) begin
            acc1_in[i] = acc1_in[i] + (ACC_W'(pa_hi_ff[i][j]) <<< HALF_W) +
                         ACC_W'(pa_lo_ff[i][j]);
         end
      end
   end

   // product of a word and a 49-bit operand, four partial products
   function automatic logic signed [PP_W-1:0] part(input logic [WORD_W-1:0] a,
                                                   input logic [D_W-1:0] b,
                                                   input int unsigned sel);
      logic signed [HALF_W:0] ah, al, bh, bl;
      logic signed [PP_W-1:0] r;
      ah = $signed({a[WORD_W-1], a[WORD_W-1:HALF_W]});
      al = $signed({1'b0, a[HALF_W-1:0]});
      bh = $signed(b[D_W-1:HALF_W]);
      bl = $signed({1'b0, b[HALF_W-1:0]});
      unique case (sel)
         0:       r = ah * bh;
         1:       r = ah * bl;
         2:       r = al * bh;
         default: r = al * bl;
      endcase
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] merge(input logic signed [PP_W-1:0] p [4]);
      return (ACC_W'(p[0]) <<< (2*HALF_W)) +
             ((ACC_W'(p[1]) + ACC_W'(p[2])) <<< HALF_W) + ACC_W'(p[3]);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc2_in[i] = (ACC_W'($signed(trn_ff[3][i])) <<< COEF_FRAC_BITS) +
                      (ACC_W'($signed(shift_ff[3][i])) <<< (2*COEF_FRAC_BITS));
         acc3_in[i] = '0;
         for (int j = 0; j < 3; j++) begin
            acc2_in[i] = acc2_in[i] + merge(pd_ff[i][j]);
            acc3_in[i] = acc3_in[i] + merge(ph_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         acc1_ff[i] <= acc1_in[i];
         f_ff[i]    <= sat_word((acc1_ff[i] + HALF1) >>> COORD_FRAC_BITS);
         for (int j = 0; j < 3; j++)
            for (int p = 0; p < 4; p++)
               pd_ff[i][j][p] <= part(rot_ff[2][i*3+j],
                                      {f_ff[j][WORD_W-1], f_ff[j]}, p);
         acc2_ff[i] <= acc2_in[i];
         g_ff[i]    <= sat_word((acc2_ff[i] + HALF2) >>> COEF_FRAC_BITS);
         d_ff[i]    <= $signed({g_ff[i][WORD_W-1], g_ff[i]}) -
                       $signed({org_ff[5][i][WORD_W-1], org_ff[5][i]});
         for (int j = 0; j < 3; j++)
            for (int p = 0; p < 4; p++)
               ph_ff[i][j][p] <= part(inv_ff[6][i*3+j], d_ff[j], p);
         acc3_ff[i] <= acc3_in[i];
         // invalid operator passes the point through
         res_ff[i]  <= side_ff[8].bad ? side_ff[8].coord[i] :
                       sat_coord((acc3_ff[i] + HALF3) >>> RND3);
      end
   end

   assign out_ctrl.valid = valid_ff[LATENCY-1];
   assign out_ctrl.bad   = side_ff[LATENCY-1].bad;
   always_comb for (int i = 0; i < 3; i++) out_result[i] = res_ff[i];

   `SCT_ASSERT_IMPLIES(a_latency_fwd, clock, reset, in_ctrl.valid, ##LATENCY out_ctrl.valid)
   `SCT_ASSERT_IMPLIES(a_latency_back, clock, reset, out_ctrl.valid,
                       $past(in_ctrl.valid, LATENCY))
   `SCT_ASSERT_IMPLIES(a_bad_pass, clock, reset, out_ctrl.valid && out_ctrl.bad,
                       out_result[0] == $past(in_coord[0], LATENCY))
endmodule
`default_nettype wire

[src/symmetry_coordinate_transform_unit.sv]
// top level: coefficient store, operator banks, issue stage and datapath
// depends on sct_pkg and sct_datapath
`default_nettype none
// Symmetry coordinate transform. A start with busy low is one transfer. busy is
// always low, so a load or a transform can be given every cycle. A transform's
// result appears on rsp_* with rsp_strobe for one cycle. The issue register loads at
// its transfer edge, holding the operator bank read, and ten datapath stages follow,
// the last of them holding the result. Loads give no result. Loads take effect for
// every later transfer, and results keep transfer order. The operator table is
// twelve banks of MAX_OPERATORS words, one read per bank per cycle. The receiver
// cannot stall.
module symmetry_coordinate_transform_unit
   import sct_pkg::*;
#(
   parameter int MAX_OPERATORS   = DEF_MAX_OPERATORS,
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_command,
   input  wire logic [ADDR_W-1:0]  req_word_address,
   input  wire logic [WORD_W-1:0]  req_word_value,
   input  wire logic [COORD_W-1:0] req_coord_x,
   input  wire logic [COORD_W-1:0] req_coord_y,
   input  wire logic [COORD_W-1:0] req_coord_z,
   input  wire logic [OPIDX_W-1:0] req_operator_index,
   input  wire logic [SHIFT_W-1:0] req_cell_shift_x,
   input  wire logic [SHIFT_W-1:0] req_cell_shift_y,
   input  wire logic [SHIFT_W-1:0] req_cell_shift_z,
   output logic                    rsp_strobe,
   output logic [COORD_W-1:0]      rsp_result_x,
   output logic [COORD_W-1:0]      rsp_result_y,
   output logic [COORD_W-1:0]      rsp_result_z,
   output logic                    rsp_bad_operator,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);
   localparam int BANK_AW = (MAX_OPERATORS > 1) ? $clog2(MAX_OPERATORS) : 1;
   localparam int REL_W   = ADDR_W;
   localparam int Q_W     = REL_W - 2;
   localparam int K_W     = Q_W;

   logic [COUNT_W-1:0] count_ff;
   logic [WORD_W-1:0]  conv_ff [CONV_WORDS];
   logic [WORD_W-1:0]  bank [OP_WORDS][MAX_OPERATORS];
   logic [WORD_W-1:0]  bank_rd_ff [OP_WORDS];

   logic               accept;
   logic               load_en;
   logic [REL_W-1:0]   rel;
   logic [Q_W+8-1:0]   kprod;
   logic [K_W-1:0]     k_idx;
   logic [3:0]         m_idx;
   logic               op_wr_en;
   logic               bad_in;

   sct_ctrl_type       issue_ff;
   logic [COORD_W-1:0] coord_ff [3];
   logic [SHIFT_W-1:0] shift_ff [3];
   logic [WORD_W-1:0]  fwd_ff [9];
   logic [WORD_W-1:0]  inv_ff [9];
   logic [WORD_W-1:0]  org_ff [3];
   logic [WORD_W-1:0]  rot_w  [9];
   logic [WORD_W-1:0]  trn_w  [3];
   sct_ctrl_type       out_ctrl;
   logic [COORD_W-1:0] out_result [3];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign load_en   = accept && (req_command == CMD_LOAD);

   // word offset split into operator and slot, rel/12 by reciprocal of 3 on rel/4
   assign rel    = req_word_address - REL_W'(OP_BASE);
   assign kprod  = (Q_W+8)'(rel[REL_W-1:2]) * (Q_W+8)'(171);
   assign k_idx  = K_W'(kprod[Q_W+8-1:9]);
   assign m_idx  = 4'(rel - REL_W'(k_idx) * REL_W'(OP_WORDS));
   assign op_wr_en = load_en && (req_word_address >= ADDR_W'(OP_BASE)) &&
                     (32'(k_idx) < MAX_OPERATORS);

   assign bad_in = ({1'b0, req_operator_index} >= count_ff) ||
                   (32'(req_operator_index) >= MAX_OPERATORS);

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_valid && csr_ready) count_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (load_en && (req_word_address < ADDR_W'(CONV_WORDS)))
         conv_ff[5'(req_word_address)] <= req_word_value;
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < OP_WORDS; b++) begin
         if (op_wr_en && (32'(m_idx) == b)) bank[b][BANK_AW'(k_idx)] <= req_word_value;
         bank_rd_ff[b] <= bank[b][BANK_AW'(req_operator_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
      end else begin
         issue_ff.valid <= accept && (req_command == CMD_XFORM);
         issue_ff.bad   <= bad_in;
      end
   end

   // snapshot of the conversion words travels with the point
   always_ff @(posedge clock) begin
      coord_ff[0] <= req_coord_x;
      coord_ff[1] <= req_coord_y;
      coord_ff[2] <= req_coord_z;
      shift_ff[0] <= req_cell_shift_x;
      shift_ff[1] <= req_cell_shift_y;
      shift_ff[2] <= req_cell_shift_z;
      for (int k = 0; k < 9; k++) begin
         fwd_ff[k] <= conv_ff[FWD_BASE+k];
         inv_ff[k] <= conv_ff[INV_BASE+k];
      end
      for (int k = 0; k < 3; k++) org_ff[k] <= conv_ff[ORG_BASE+k];
   end

   always_comb begin
      for (int k = 0; k < 9; k++) rot_w[k] = bank_rd_ff[k];
      for (int k = 0; k < 3; k++) trn_w[k] = bank_rd_ff[TRN_OFS+k];
   end

   sct_datapath #(
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_ctrl    (issue_ff),
      .in_coord   (coord_ff),
      .in_shift   (shift_ff),
      .in_fwd     (fwd_ff),
      .in_inv     (inv_ff),
      .in_org     (org_ff),
      .in_rot     (rot_w),
      .in_trn     (trn_w),
      .out_ctrl   (out_ctrl),
      .out_result (out_result)
   );

   assign rsp_strobe       = out_ctrl.valid;
   assign rsp_bad_operator = out_ctrl.bad;
   assign rsp_result_x     = out_result[0];
   assign rsp_result_y     = out_result[1];
   assign rsp_result_z     = out_result[2];
endmodule
`default_nettype wire
